[sv/efe_pkg.sv]
// ---------------------------------------------------------------------------
// efe_pkg: shared definitions for the escaped frame encoder
// Byte type, register indexes, reset values and the slot layout of the
// per-item output list.
// ---------------------------------------------------------------------------
package efe_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] slot_idx_t;

  localparam int NUM_SLOTS = 5;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  localparam logic REG_BEGIN  = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  localparam byte_t BEGIN_RESET  = 8'hFF;
  localparam byte_t ESCAPE_RESET = 8'hFD;

  localparam slot_idx_t SLOT_BEGIN = 3'd0;
  localparam slot_idx_t SLOT_ESC_B = 3'd1;
  localparam slot_idx_t SLOT_BYTE  = 3'd2;
  localparam slot_idx_t SLOT_ESC_C = 3'd3;
  localparam slot_idx_t SLOT_CKS   = 3'd4;

endpackage

[sv/escaped_frame_encoder.sv]
// ---------------------------------------------------------------------------
// escaped_frame_encoder: byte-stuffing framer with a subtractive checksum
//
// Packet bytes enter on the s_axis channel, the command byte marked by tuser
// and the final byte by tlast. Each item is expanded into one to five encoded
// bytes on the m_axis channel: the raw begin byte when a packet starts, the
// escaped packet byte, and the escaped checksum after the final byte. The
// output tlast marks the last byte caused by an item, and tuser marks the
// closing checksum byte of a frame.
// An accepted item is held in the pending byte list and then moves out
// through the single output register, one encoded byte per cycle while the
// receiver is ready. A new item is taken in the cycle that the last byte of
// the previous one moves out.
// The cfg channel writes the begin and escape values; it is always ready.
// Reset restores the default marker values, clears the checksum and drops
// all pending bytes. When the receiver stalls, the output holds and the
// input channel stops after the current item.
// ---------------------------------------------------------------------------
module escaped_frame_encoder (
  input  logic            clk,
  input  logic            rst,
  // Configuration write channel.
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  efe_pkg::byte_t  cfg_data,
  // Input items.
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  efe_pkg::byte_t  s_axis_tdata,   // [7:0] byte_value
  input  logic            s_axis_tuser,   // [0] first_of_packet
  input  logic            s_axis_tlast,   // last_of_packet
  // Encoded output items.
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output efe_pkg::byte_t  m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tuser,   // [0] frame_end
  output logic            m_axis_tlast    // last_of_run
);
  import efe_pkg::*;

  byte_t      begin_val;
  byte_t      escape_val;
  byte_t      checksum;
  byte_t      checksum_next;
  slot_mask_t pend_mask;
  slot_mask_t pend_mask_next;
  byte_t      pend_byte [NUM_SLOTS];
  slot_mask_t new_mask;
  byte_t      new_byte [NUM_SLOTS];
  byte_t      cs_base;
  byte_t      cs_new;
  logic       esc_b;
  logic       esc_c;
  slot_idx_t  sel_idx;
  slot_mask_t rem_mask;
  logic       out_free;
  logic       move;
  logic       accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_val  <= BEGIN_RESET;
      escape_val <= ESCAPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BEGIN:  begin_val  <= cfg_data;
        REG_ESCAPE: escape_val <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    cs_base = s_axis_tuser ? (8'd0 - begin_val) : checksum;
    cs_new  = cs_base - s_axis_tdata;
    esc_b   = (s_axis_tdata == begin_val) || (s_axis_tdata == escape_val);
    esc_c   = (cs_new == begin_val) || (cs_new == escape_val);

    new_byte[SLOT_BEGIN] = begin_val;
    new_byte[SLOT_ESC_B] = escape_val;
    new_byte[SLOT_BYTE]  = esc_b ? (s_axis_tdata - 8'd1) : s_axis_tdata;
    new_byte[SLOT_ESC_C] = escape_val;
    new_byte[SLOT_CKS]   = esc_c ? (cs_new - 8'd1) : cs_new;

    new_mask             = '0;
    new_mask[SLOT_BEGIN] = s_axis_tuser;
    new_mask[SLOT_ESC_B] = esc_b;
    new_mask[SLOT_BYTE]  = 1'b1;
    new_mask[SLOT_ESC_C] = s_axis_tlast && esc_c;
    new_mask[SLOT_CKS]   = s_axis_tlast;
  end

  always_comb begin
    sel_idx = SLOT_CKS;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        sel_idx = slot_idx_t'(i);
      end
    end
    rem_mask          = pend_mask;
    rem_mask[sel_idx] = 1'b0;
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign move          = (pend_mask != '0) && out_free;
  assign s_axis_tready = (pend_mask == '0) || (move && (rem_mask == '0));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    checksum_next  = checksum;
    pend_mask_next = pend_mask;
    if (accept) begin
      checksum_next  = s_axis_tlast ? 8'd0 : cs_new;
      pend_mask_next = new_mask;
    end else if (move) begin
      pend_mask_next = rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum  <= '0;
      pend_mask <= '0;
    end else begin
      checksum  <= checksum_next;
      pend_mask <= pend_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_byte <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_axis_tdata <= pend_byte[sel_idx];
      m_axis_tlast <= (rem_mask == '0);
      m_axis_tuser <= (sel_idx == SLOT_CKS);
    end
  end

  a_frame_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end byte not marked as last of run");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend_mask != '0)
    else $error("accepted item left no pending bytes");

  a_cks_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> checksum == 8'd0)
    else $error("checksum not cleared after packet end");

  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    move |=> m_axis_tvalid)
    else $error("moved byte not presented on output");

endmodule

[test/tb_escaped_frame_encoder.sv]
// ---------------------------------------------------------------------------
// tb_escaped_frame_encoder: self-checking bench for the escaped frame encoder
// A queue of packet bytes feeds a driver that offers one item at a time with
// random gaps, while the output side stalls at random. Every accepted input
// item is run through a local model of the framer (begin marker, escaping and
// the subtractive checksum), and every encoded byte that leaves the block is
// checked against the oldest predicted byte. The marker values are changed
// between phases, only while the block is idle.
// ---------------------------------------------------------------------------
module tb_escaped_frame_encoder;
  import efe_pkg::*;

  typedef struct packed {
    byte_t value;
    logic  first;
    logic  last;
  } pkt_item_t;

  typedef struct packed {
    byte_t data;
    logic  run_end;
    logic  frame_end;
  } enc_byte_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_index = REG_BEGIN;
  byte_t cfg_data = '0;
  logic  s_axis_tvalid = 1'b0;
  logic  s_axis_tready;
  byte_t s_axis_tdata = '0;
  logic  s_axis_tuser = 1'b0;
  logic  s_axis_tlast = 1'b0;
  logic  m_axis_tvalid;
  logic  m_axis_tready = 1'b0;
  byte_t m_axis_tdata;
  logic  m_axis_tuser;
  logic  m_axis_tlast;

  pkt_item_t pending_bytes[$];
  enc_byte_t expected_bytes[$];

  byte_t marker_begin = BEGIN_RESET;
  byte_t marker_escape = ESCAPE_RESET;
  byte_t frame_sum = '0;
  byte_t stim_begin = BEGIN_RESET;
  byte_t stim_escape = ESCAPE_RESET;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic calm = 1'b0;
  int   idle_left = 0;
  int   stall_left = 0;
  int   items_queued = 0;
  int   items_accepted = 0;
  int   mismatches = 0;
  pkt_item_t drive_item;
  enc_byte_t want;

  escaped_frame_encoder uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Expands one packet byte into its encoded bytes and updates the checksum.
  task automatic encode_item(input pkt_item_t it);
    byte_t outs[5];
    logic  ends[5];
    byte_t v;
    int    n;
    int    s;
    n = 0;
    if (it.first) begin
      frame_sum = '0;
      outs[n] = marker_begin;
      ends[n] = 1'b0;
      n++;
      frame_sum = frame_sum - marker_begin;
    end
    for (s = 0; s < 2; s++) begin
      if (s == 0 || it.last) begin
        v = (s == 0) ? it.value : frame_sum;
        if (v == marker_begin || v == marker_escape) begin
          outs[n] = marker_escape;
          ends[n] = 1'b0;
          n++;
          v = v - 8'd1;
        end
        outs[n] = v;
        ends[n] = (s == 1);
        n++;
        if (s == 0) begin
          frame_sum = frame_sum - it.value;
        end
      end
    end
    if (it.last) begin
      frame_sum = '0;
    end
    for (s = 0; s < n; s++) begin
      expected_bytes.push_back('{outs[s], (s == n - 1), ends[s]});
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      idle_left <= 0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (idle_left > 0) begin
        s_axis_tvalid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_bytes.size() > 0) begin
        drive_item = pending_bytes.pop_front();
        s_axis_tdata <= drive_item.value;
        s_axis_tuser <= drive_item.first;
        s_axis_tlast <= drive_item.last;
        s_axis_tvalid <= 1'b1;
        idle_left <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
      marker_begin = BEGIN_RESET;
      marker_escape = ESCAPE_RESET;
      frame_sum = '0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BEGIN) begin
          marker_begin = cfg_data;
        end else begin
          marker_escape = cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encode_item('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
        items_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %02h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.run_end) begin
            $error("last_of_run: expected %0b, actual %0b", want.run_end, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, m_axis_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic queue_byte(input byte_t value, input logic first, input logic last);
    pending_bytes.push_back('{value, first, last});
    items_queued++;
  endtask

  // Favors the marker values and their neighbors so that escaping is common.
  function automatic byte_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      return stim_begin;
    end else if (r < 34) begin
      return stim_escape;
    end else if (r < 40) begin
      return stim_begin - 8'd1;
    end else if (r < 46) begin
      return stim_escape + 8'd1;
    end else if (r < 52) begin
      return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    end
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed packets; some lack the start mark, some the end mark,
  // and some are loose bytes outside any packet.
  task automatic queue_packet();
    int    mode;
    int    body_len;
    int    i;
    logic  no_first;
    logic  no_last;
    byte_t len_val;
    mode = $urandom_range(0, 99);
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    no_first = (mode >= 10 && mode < 16);
    no_last = (mode >= 16 && mode < 22);
    if (mode < 6) begin
      queue_byte(pick_value(), 1'b1, 1'b1);
    end else if (mode < 10) begin
      for (i = 0; i <= body_len % 3; i++) begin
        queue_byte(pick_value(), 1'b0, 1'b0);
      end
    end else begin
      len_val = (mode % 7 == 0) ? pick_value() : byte_t'(body_len);
      queue_byte(pick_value(), !no_first, 1'b0);
      queue_byte(len_val, 1'b0, (body_len == 0) && !no_last);
      for (i = 0; i < body_len; i++) begin
        queue_byte(pick_value(), 1'b0, (i == body_len - 1) && !no_last);
      end
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (items_accepted != items_queued || expected_bytes.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input byte_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
    end while (!cfg_taken);
    cfg_valid <= 1'b0;
    if (idx == REG_BEGIN) begin
      stim_begin = val;
    end else begin
      stim_escape = val;
    end
  endtask

  initial begin
    byte_t begins[6];
    byte_t escapes[6];
    int    p;
    int    target;
    begins = '{8'h00, 8'h7E, 8'hFF, 8'h00, 8'h00, 8'h00};
    escapes = '{8'hFF, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00};
    for (p = 3; p < 6; p++) begin
      begins[p] = byte_t'($urandom_range(0, 255));
      escapes[p] = ($urandom_range(0, 3) == 0) ? begins[p] : byte_t'($urandom_range(0, 255));
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset marker values: escaping of both markers, checksums that need
    // escaping, loose bytes, a restart inside a packet and single-byte packets.
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFD, 1'b0, 1'b0);
    queue_byte(8'hFE, 1'b0, 1'b0);
    queue_byte(8'hFC, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_byte(8'h02, 1'b1, 1'b1);
    queue_byte(8'h04, 1'b1, 1'b1);
    queue_byte(8'h12, 1'b0, 1'b0);
    queue_byte(8'hFD, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b1);
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'h02, 1'b0, 1'b0);
    queue_byte(8'h03, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h55, 1'b1, 1'b0);
    queue_byte(8'hAA, 1'b0, 1'b1);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      repeat (4) @(negedge clk);
      write_reg(REG_BEGIN, begins[p]);
      write_reg(REG_ESCAPE, escapes[p]);
      calm = (p % 3 == 2);
      target = items_queued + 75;
      while (items_queued < target) begin
        queue_packet();
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
